// ===== hw/rtl/phash_pkg.sv =====
// ----------------------------------------------------------------------------
// phash_pkg: shared types and constants for the multi-lane pearson hash
// Holds the byte substitution table, the configuration register indexes and
// the control group passed from the top level to each lane.
// ----------------------------------------------------------------------------
`default_nettype none

package phash_pkg;

    typedef logic [7:0] byte_t;

    localparam int HASH_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_OFFSET     = 2'd0,
        CFG_SEED_DESCENDING = 2'd1
    } cfg_index_t;

    // per-lane control for one cycle
    typedef struct packed {
        logic step;    // substitute the current key byte
        logic reload;  // load the seed after any substitution
    } lane_ctrl_t;

    // byte substitution table
    localparam byte_t ROUTE_TABLE [256] = '{
        8'd134, 8'd69,  8'd160, 8'd77,  8'd51,  8'd124, 8'd187, 8'd253,
        8'd14,  8'd23,  8'd105, 8'd142, 8'd91,  8'd43,  8'd231, 8'd238,
        8'd47,  8'd154, 8'd190, 8'd84,  8'd219, 8'd242, 8'd36,  8'd123,
        8'd17,  8'd239, 8'd2,   8'd67,  8'd229, 8'd162, 8'd143, 8'd73,
        8'd200, 8'd120, 8'd117, 8'd104, 8'd108, 8'd60,  8'd177, 8'd224,
        8'd133, 8'd110, 8'd225, 8'd100, 8'd92,  8'd216, 8'd171, 8'd149,
        8'd10,  8'd98,  8'd55,  8'd227, 8'd165, 8'd76,  8'd156, 8'd128,
        8'd204, 8'd251, 8'd48,  8'd118, 8'd255, 8'd163, 8'd193, 8'd89,
        8'd203, 8'd155, 8'd130, 8'd210, 8'd244, 8'd146, 8'd86,  8'd95,
        8'd127, 8'd208, 8'd21,  8'd213, 8'd97,  8'd221, 8'd240, 8'd63,
        8'd94,  8'd226, 8'd248, 8'd88,  8'd7,   8'd207, 8'd246, 8'd218,
        8'd148, 8'd114, 8'd222, 8'd59,  8'd175, 8'd150, 8'd173, 8'd122,
        8'd212, 8'd35,  8'd8,   8'd30,  8'd166, 8'd33,  8'd206, 8'd16,
        8'd152, 8'd41,  8'd237, 8'd52,  8'd66,  8'd186, 8'd198, 8'd235,
        8'd65,  8'd232, 8'd112, 8'd140, 8'd71,  8'd116, 8'd132, 8'd99,
        8'd0,   8'd215, 8'd28,  8'd158, 8'd249, 8'd135, 8'd87,  8'd171,
        8'd192, 8'd164, 8'd85,  8'd27,  8'd90,  8'd179, 8'd233, 8'd49,
        8'd136, 8'd57,  8'd172, 8'd53,  8'd168, 8'd250, 8'd12,  8'd20,
        8'd234, 8'd13,  8'd121, 8'd38,  8'd70,  8'd58,  8'd129, 8'd185,
        8'd151, 8'd82,  8'd113, 8'd230, 8'd125, 8'd201, 8'd50,  8'd223,
        8'd196, 8'd6,   8'd78,  8'd106, 8'd184, 8'd202, 8'd145, 8'd62,
        8'd5,   8'd174, 8'd79,  8'd83,  8'd26,  8'd44,  8'd25,  8'd245,
        8'd81,  8'd71,  8'd147, 8'd211, 8'd195, 8'd31,  8'd153, 8'd19,
        8'd72,  8'd119, 8'd188, 8'd126, 8'd205, 8'd46,  8'd194, 8'd74,
        8'd241, 8'd252, 8'd29,  8'd64,  8'd138, 8'd40,  8'd167, 8'd18,
        8'd247, 8'd199, 8'd22,  8'd181, 8'd115, 8'd243, 8'd37,  8'd103,
        8'd183, 8'd180, 8'd137, 8'd4,   8'd169, 8'd209, 8'd80,  8'd96,
        8'd228, 8'd54,  8'd3,   8'd56,  8'd144, 8'd178, 8'd34,  8'd191,
        8'd93,  8'd159, 8'd24,  8'd131, 8'd107, 8'd139, 8'd197, 8'd1,
        8'd109, 8'd217, 8'd15,  8'd32,  8'd170, 8'd236, 8'd101, 8'd141,
        8'd68,  8'd39,  8'd157, 8'd176, 8'd75,  8'd9,   8'd254, 8'd45,
        8'd42,  8'd182, 8'd189, 8'd102, 8'd220, 8'd214, 8'd11,  8'd111
    };

endpackage

`default_nettype wire

// ===== hw/rtl/phash_lane.sv =====
// ----------------------------------------------------------------------------
// phash_lane: one 8-bit hash lane
// Substitutes key byte xor lane through the table and reloads the seed at the
// end of a key or on a configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

module phash_lane
    import phash_pkg::*;
#(
    parameter logic [7:0] RESET_VAL = 8'd0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lane_ctrl_t ctrl,
    input  wire byte_t      key_byte,
    input  wire byte_t      seed,
    output byte_t           lane_upd
);

    byte_t lane_reg;
    byte_t lane_next;

    // value after this beat's byte, before any reload
    always_comb
    begin
        lane_upd = ctrl.step ? ROUTE_TABLE[key_byte ^ lane_reg] : lane_reg;
    end

    always_comb
    begin
        lane_next = ctrl.reload ? seed : lane_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= RESET_VAL;
        end
        else
        begin
            lane_reg <= lane_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_lane_pearson_hash.sv =====
// ----------------------------------------------------------------------------
// multi_lane_pearson_hash: eight-lane pearson hash over a byte stream
// Input register, per-lane table substitution and a result register.
// ----------------------------------------------------------------------------
// usage
//   input channel: one key byte per beat (data_byte, has_byte, last) under
//   in_valid / in_stall. a beat with last set ends the key and yields one
//   hash beat on the output channel (hash_value under out_valid / out_stall);
//   a beat with has_byte clear adds no byte, so last alone hashes the seed.
//   config: cfg_we with cfg_index / cfg_data writes seed_offset (index 0) or
//   seed_descending (index 1) and reloads all lanes with the new seed. other
//   indexes are ignored. write only while the block is idle.
//   path: an accepted last beat waits in the input register, then loads its
//   hash into the result register, from which the hash beat is offered.
//   throughput: one beat per cycle unless in_stall is high; the lane update
//   is a single table lookup per lane between the input and lane registers.
//   stall: the input register keeps taking beats while a hash waits; a last
//   beat held behind a stalled hash stalls the input until the hash goes.
//   reset: empty pipeline, offset 0 ascending, lane i holds i.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_lane_pearson_hash
    import phash_pkg::*;
#(
    parameter int LANES = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // key bytes
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  has_byte,
    input  wire logic                  last,
    // hashes
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [HASH_W-1:0]          hash_value
);

    // configuration registers
    byte_t seed_offset_reg;
    byte_t seed_offset_next;
    logic  seed_desc_reg;
    logic  seed_desc_next;
    logic  cfg_reload;

    // input register
    logic  in_valid_reg;
    logic  in_valid_next;
    byte_t key_byte_reg;
    logic  has_byte_reg;
    logic  last_reg;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;

    logic       in_accept;
    logic       proc_fire;
    lane_ctrl_t lane_ctrl;
    byte_t      lane_upd [LANES];
    byte_t      lane_seed [LANES];

    // ---------------------------------------------------------------- config
    assign cfg_reload = cfg_we && (cfg_index == CFG_SEED_OFFSET ||
                                   cfg_index == CFG_SEED_DESCENDING);

    always_comb
    begin
        seed_offset_next = seed_offset_reg;
        seed_desc_next   = seed_desc_reg;
        if (cfg_we && cfg_index == CFG_SEED_OFFSET)
        begin
            seed_offset_next = cfg_data[7:0];
        end
        if (cfg_we && cfg_index == CFG_SEED_DESCENDING)
        begin
            seed_desc_next = cfg_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_offset_reg <= 8'd0;
            seed_desc_reg   <= 1'b0;
        end
        else
        begin
            seed_offset_reg <= seed_offset_next;
            seed_desc_reg   <= seed_desc_next;
        end
    end

    // ---------------------------------------------------------- handshakes
    // the held beat moves on unless it ends a key and the hash slot is
    // still occupied by a stalled result
    assign proc_fire = in_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc_fire;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_byte_reg <= data_byte;
            has_byte_reg <= has_byte;
            last_reg     <= last;
        end
    end

    // ---------------------------------------------------------------- lanes
    // substitution happens before the reload, so a last beat with a byte
    // hashes that byte first
    always_comb
    begin
        lane_ctrl.step   = proc_fire && has_byte_reg;
        lane_ctrl.reload = (proc_fire && last_reg) || cfg_reload;
    end

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        localparam logic [7:0] ASC_IDX  = 8'(j);
        localparam logic [7:0] DESC_IDX = 8'(LANES - 1 - j);

        // seed from the register values that will stand after this edge
        assign lane_seed[j] = seed_offset_next + (seed_desc_next ? DESC_IDX : ASC_IDX);

        phash_lane #(
            .RESET_VAL (ASC_IDX)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .key_byte (key_byte_reg),
            .seed     (lane_seed[j]),
            .lane_upd (lane_upd[j])
        );
    end

    // lane 0 in the top used byte, unused upper bytes zero
    always_comb
    begin
        hash_next = '0;
        for (int j = 0; j < LANES; j++)
        begin
            hash_next[(LANES - 1 - j) * 8 +: 8] = lane_upd[j];
        end
    end

    // --------------------------------------------------------------- result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_fire && last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && last_reg)
        begin
            hash_reg <= hash_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // ----------------------------------------------------------- assertions
    // a finished key always lands in the result register
    a_last_gives_hash: assert property (
        @(posedge clk) disable iff (!rst_n)
        (proc_fire && last_reg) |=> out_valid
    ) else $error("hash not presented after a last beat");

    // the input only stalls behind a held beat
    a_stall_needs_beat: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && last_reg && out_valid_reg && out_stall)
    ) else $error("input stalled without a blocked beat");

    // unused upper bytes of the hash stay zero
    a_hash_upper_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((hash_value >> (LANES * 8)) == '0)
    ) else $error("hash has bits above the used lanes");

    // a held hash is only replaced once it has been taken
    a_hash_not_lost: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(hash_value))
    ) else $error("stalled hash overwritten");

endmodule

`default_nettype wire

// ===== tb/tb_multi_lane_pearson_hash.sv =====
// ----------------------------------------------------------------------------
// tb_multi_lane_pearson_hash: self-checking bench for the eight-lane hash
// Streams keys through the byte channel under random bursts, gaps and output
// stalls. A local lane model predicts every hash, and each hash beat is
// compared in order. Seed settings, key abandonment on a register write,
// ignored spare indexes and a long output hold-off are all exercised.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_lane_pearson_hash
    import phash_pkg::*;
();

    localparam int NUM_LANES      = 8;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int MAX_REPORTS    = 20;

    // indexes past the two real registers, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // type offsets used by the fixed-size key variants, plus the top value
    localparam byte_t SEED_OFFSETS [6] = '{8'd0, 8'd31, 8'd63, 8'd95, 8'd127, 8'd255};

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    // every input gets a known value from time zero
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [7:0]            data_byte  = '0;
    logic                  has_byte   = 1'b0;
    logic                  last       = 1'b0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [HASH_W-1:0]     hash_value;

    // lane model and the hashes still owed by the block
    byte_t             lane_state [NUM_LANES];
    byte_t             model_offset;
    logic              model_descending;
    logic [HASH_W-1:0] pending_hashes [$];

    int  mismatches   = 0;
    int  burst_left   = 0;
    int  quiet_cycles = 0;
    bit  hold_req     = 1'b0;

    multi_lane_pearson_hash #(
        .LANES      (NUM_LANES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // lane model
    // ------------------------------------------------------------------------

    // lane i takes (i + offset) mod 256; descending mode mirrors the lane order
    function automatic void load_lane_seed();
        byte_t v;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            v = byte_t'(i) + model_offset;
            if (model_descending)
                lane_state[NUM_LANES - 1 - i] = v;
            else
                lane_state[i] = v;
        end
    endfunction

    // one accepted beat: substitute the byte into every lane, and on last
    // pack the lanes (lane 0 uppermost) into an owed hash and reseed
    function automatic void absorb_beat(input byte_t b, input logic hb, input logic lst);
        logic [HASH_W-1:0] h;
        if (hb)
        begin
            for (int j = 0; j < NUM_LANES; j++)
                lane_state[j] = ROUTE_TABLE[b ^ lane_state[j]];
        end
        if (lst)
        begin
            h = '0;
            for (int j = 0; j < NUM_LANES; j++)
                h = {h[HASH_W-9:0], lane_state[j]};
            pending_hashes.push_back(h);
            load_lane_seed();
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // offers one beat and waits for it to be taken; bursts of random length
    // are separated by random gaps with valid low, and some bursts are long
    // enough to leave the input busy for a good stretch
    task automatic send_beat(input byte_t b, input logic hb, input logic lst);
        int r;
        int gap;
        in_valid  <= 1'b1;
        data_byte <= b;
        has_byte  <= hb;
        last      <= lst;
        do @(posedge clk); while (in_stall);
        absorb_beat(b, hb, lst);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            r          = $urandom_range(0, 9);
            burst_left = (r == 0) ? $urandom_range(100, 200) : $urandom_range(0, 15);
            gap        = (r < 4) ? 0 : $urandom_range(1, (r < 8) ? 3 : 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stops offering beats until every owed hash is back, then lets the
    // pipeline empty so that no byte is left between the input and the lanes
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // a real register write reseeds the lanes; spare indexes change nothing
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SEED_OFFSET)
        begin
            model_offset = val;
            load_lane_seed();
        end
        else if (idx == CFG_SEED_DESCENDING)
        begin
            model_descending = val[0];
            load_lane_seed();
        end
        @(posedge clk);
    endtask

    // any register, with the well-known offsets favoured
    task automatic write_random_reg();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            write_reg(CFG_SEED_OFFSET, ($urandom_range(0, 1) == 0) ?
                      SEED_OFFSETS[$urandom_range(0, 5)] : byte_t'($urandom_range(0, 255)));
        else if (r < 9)
            write_reg(CFG_SEED_DESCENDING, byte_t'($urandom_range(0, 255)));
        else
            write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                      byte_t'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // receiver: stall pattern of its own, switching between no stall, light,
    // heavy and alternate-cycle stalling; a hold request forces a long
    // hold-off counted here
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        stall_mode_t mode;
        int          phase_left;
        int          hold_left;
        mode       = STALL_NONE;
        phase_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = stall_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(10, 80);
                end
                phase_left--;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // hash checker: every accepted hash beat against the oldest owed hash
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [HASH_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hashes.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: hash beat with none owed: expected none, got %h",
                             $time, hash_value);
                mismatches++;
            end
            else
            begin
                want = pending_hashes.pop_front();
                if (hash_value !== want)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: hash_value mismatch: expected %h, got %h",
                                 $time, want, hash_value);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any beat taken on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset seed: empty key hashes the seed alone, then single-byte keys at
    // the byte extremes; the byte on an end-only beat must be ignored
    task automatic test_reset_seed();
        send_beat(8'hA5, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
    endtask

    // multi-byte keys with alternating bit patterns, an idle beat inside a
    // key, and both ways of ending a key
    task automatic test_key_bytes();
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'h3C, 1'b0, 1'b0);
        send_beat(8'hAA, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(8'h01, 1'b1, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h7F, 1'b1, 1'b0);
        send_beat(8'hFE, 1'b1, 1'b1);
    endtask

    // the type offsets but 0 and the top offset, in alternating lane orders;
    // only bit 0 of the descending register counts
    task automatic test_seed_settings();
        for (int k = 1; k < 6; k++)
        begin
            drain_block();
            write_reg(CFG_SEED_OFFSET, SEED_OFFSETS[k]);
            write_reg(CFG_SEED_DESCENDING, (k % 2 == 1) ? 8'hFF : 8'hFE);
            send_beat(8'h00, 1'b0, 1'b1);
        end
        send_beat(8'h5A, 1'b1, 1'b1);
    endtask

    // a spare index must leave a key in progress alone, while a real write
    // throws the partial key away and reseeds
    task automatic test_key_abandon();
        send_beat(8'h11, 1'b1, 1'b0);
        send_beat(8'h22, 1'b1, 1'b0);
        drain_block();
        write_reg(CFG_SPARE_A, 8'hFF);
        write_reg(CFG_SPARE_B, 8'h01);
        send_beat(8'h33, 1'b1, 1'b1);
        send_beat(8'h44, 1'b1, 1'b0);
        send_beat(8'h55, 1'b1, 1'b0);
        drain_block();
        write_reg(CFG_SEED_OFFSET, 8'd0);
        write_reg(CFG_SEED_DESCENDING, 8'd0);
        send_beat(8'h66, 1'b1, 1'b1);
    endtask

    // output held off for a long stretch while keys keep coming, so the block
    // fills and stalls its input; then a pause until every hash is back
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++)
        begin
            send_beat(byte_t'($urandom_range(0, 255)), 1'b1, 1'b0);
            send_beat(byte_t'($urandom_range(0, 255)), 1'b1, 1'b0);
            send_beat(byte_t'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
        drain_block();
    endtask

    // random keys: mostly short, some long, a few empty; idle beats sprinkled
    // in; register writes between keys and now and then part way through one
    task automatic test_random_keys();
        int    sent;
        int    len;
        int    r;
        int    cut;
        bit    end_on_byte;
        byte_t b;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                drain_block();
                write_random_reg();
            end
            r           = $urandom_range(0, 99);
            len         = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            end_on_byte = (len != 0) && ($urandom_range(0, 2) != 0);
            cut         = (len > 1 && $urandom_range(0, 19) == 0) ? len / 2 : -1;
            for (int j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0);
                if (j == cut)
                begin
                    drain_block();
                    write_random_reg();
                end
                b = byte_t'($urandom_range(0, 255));
                send_beat(b, 1'b1, end_on_byte && (j == len - 1));
                sent++;
            end
            if (!end_on_byte)
            begin
                send_beat(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        model_offset     = 8'd0;
        model_descending = 1'b0;
        load_lane_seed();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_seed();
        test_key_bytes();
        test_seed_settings();
        test_key_abandon();
        test_backpressure();
        test_random_keys();

        // nothing left in flight; the watchdog bounds this wait
        drain_block();

        if (mismatches == 0 && pending_hashes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== multi_lane_pearson_hash.f =====
hw/rtl/phash_pkg.sv
hw/rtl/phash_lane.sv
hw/rtl/multi_lane_pearson_hash.sv
tb/tb_multi_lane_pearson_hash.sv
